@@ rtl/tama_pkg.sv @@
// Shared constants and types for the three-axis moving average.
package tama_pkg;

   localparam int SAMPLE_W = 13;
   localparam int AXES     = 3;
   localparam int WINDOW   = 8;
   // The mean is taken by an arithmetic shift, so the window must be a power of two.
   localparam int SHIFT    = $clog2(WINDOW);
   localparam int POS_W    = $clog2(WINDOW);
   localparam int SUM_W    = SAMPLE_W + SHIFT;
   localparam int SET_W    = AXES * SAMPLE_W;
   localparam int DATA_W   = ((SET_W + 7) / 8) * 8;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [POS_W-1:0]           pos_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   typedef struct packed {
      sample_type y;
      sample_type z;
      sample_type x;
   } axes_type;

   typedef struct packed {
      logic read;
      logic write;
   } ring_ctrl_type;

endpackage

@@ rtl/tama_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module tama_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tama_ring.sv @@
// Sample ring: RAM, per-entry valid bits and the shared ring position.
module tama_ring
   import tama_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ring_ctrl_type ctrl,
   input  axes_type      wr_set,
   output axes_type      old_set
);

   pos_type           pos_ff, pos_in;
   pos_type           wr_pos_ff;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic              old_valid_ff;
   logic [SET_W-1:0]  rd_data;

   tama_ram #(
      .WIDTH(SET_W),
      .DEPTH(WINDOW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ctrl.write),
      .wr_addr(wr_pos_ff),
      .wr_data(wr_set),
      .rd_en  (ctrl.read),
      .rd_addr(pos_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (ctrl.read) begin
         pos_in = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
      end
      if (ctrl.write) begin
         valid_in[wr_pos_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // The write address follows the read of the same item by one stage.
   always_ff @(posedge clock) begin
      if (ctrl.read) begin
         wr_pos_ff    <= pos_ff;
         old_valid_ff <= valid_ff[pos_ff];
      end
   end

   // An entry never written since reset reads as zero.
   assign old_set = old_valid_ff ? axes_type'(rd_data) : '0;

endmodule

@@ rtl/tama_accum.sv @@
// Running window sums per axis and the registered averages.
module tama_accum
   import tama_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  axes_type new_set,
   input  axes_type old_set,
   output axes_type avg_set
);

   sum_type  sum_x_ff, sum_y_ff, sum_z_ff;
   sum_type  sum_x_in, sum_y_in, sum_z_in;
   sum_type  shr_x, shr_y, shr_z;
   axes_type avg_ff;

   always_comb begin
      sum_x_in = sum_x_ff + SUM_W'(new_set.x) - SUM_W'(old_set.x);
      sum_y_in = sum_y_ff + SUM_W'(new_set.y) - SUM_W'(old_set.y);
      sum_z_in = sum_z_ff + SUM_W'(new_set.z) - SUM_W'(old_set.z);
      shr_x    = sum_x_in >>> SHIFT;
      shr_y    = sum_y_in >>> SHIFT;
      shr_z    = sum_z_in >>> SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
      end else if (step) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         avg_ff.x <= shr_x[SAMPLE_W-1:0];
         avg_ff.y <= shr_y[SAMPLE_W-1:0];
         avg_ff.z <= shr_z[SAMPLE_W-1:0];
      end
   end

   assign avg_set = avg_ff;

endmodule

@@ rtl/three_axis_moving_average.sv @@
// Top level of the three-axis eight-sample moving average.
//
// One transfer on the req_ channel carries a sample set of three signed
// 13-bit readings in sensor register order X, Z, Y. One transfer on the
// rsp_ channel returns the floor mean of the last eight readings of each
// axis, in the order X, Y, Z. Every request yields exactly one response.
//
// The readings live in a small ring RAM, one word per position holding all
// three axes. Each request reads the entry it is about to replace; the old
// entry then comes out of the RAM's read register, and when the set leaves
// the read stage the new set is written in its place and the running sums
// are corrected by the difference. A request passes the read stage register
// and then the response register before rsp_tvalid rises. While the
// receiver keeps rsp_tready high, a new request is taken every cycle; the
// rate is set by the single RAM read and write per item, which never touch
// the same entry at once.
// Reset clears the ring position, the running sums and the per-entry valid
// bits, so unwritten entries count as zero and the first seven results mix
// in zeros. When the receiver stalls, the response register holds, one
// more request can sit in the RAM read stage, and req_tready then drops.
module three_axis_moving_average
   import tama_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // x_raw [12:0], z_raw [25:13], y_raw [38:26], zero [39]
   input  logic [DATA_W-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // avg_x [12:0], avg_y [25:13], avg_z [38:26], zero [39]
   output logic [DATA_W-1:0] rsp_tdata
);

   logic          s1_valid_ff, s1_valid_in;
   logic          out_valid_ff, out_valid_in;
   logic          accept;
   logic          advance;
   axes_type      req_set;
   axes_type      s1_set_ff;
   axes_type      old_set;
   axes_type      avg_set;
   ring_ctrl_type ring_ctrl;

   // The wire order of the request is X, Z, Y; the internal set is by axis.
   assign req_set.x = req_tdata[SAMPLE_W-1:0];
   assign req_set.z = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
   assign req_set.y = req_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

   // The read stage moves on whenever the response register is free or drains.
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign ring_ctrl.read  = accept;
   assign ring_ctrl.write = advance;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : ((rsp_tready) ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_set_ff <= req_set;
      end
   end

   tama_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ring_ctrl),
      .wr_set (s1_set_ff),
      .old_set(old_set)
   );

   tama_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .new_set(s1_set_ff),
      .old_set(old_set),
      .avg_set(avg_set)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(DATA_W - SET_W){1'b0}}, avg_set.z, avg_set.y, avg_set.x};

   // An accepted request always occupies the read stage in the next cycle.
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request did not enter the read stage");

   // A set leaving the read stage always produces a response.
   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("read stage advanced without a response");

   // A blocked read stage keeps its set and its valid flag.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_set_ff)))
      else $error("stalled read stage lost its contents");

endmodule
